FILE: sv/ale_pkg.sv
package ale_pkg;

	localparam int unsigned XW = 32;
	localparam int unsigned VW = 64;
	localparam int unsigned LW = 5;
	localparam int unsigned KW = 6;

	localparam logic [VW-1:0] VMAX = {1'b0, {(VW-1){1'b1}}};
	localparam logic [VW-1:0] VMIN = {1'b1, {(VW-1){1'b0}}};
	localparam logic [VW-1:0] ONE_Q20 = 64'd1 << 20;
	localparam logic signed [XW-1:0] ONE_Q30 = 32'sd1073741824;

	typedef enum logic [4:0] {
		OP_NOP,
		OP_LOAD,
		OP_RAD,
		OP_SQRT,
		OP_W_ONE,
		OP_W_ZERO,
		OP_W_P1,
		OP_MQLO_S,
		OP_MQLO_X,
		OP_MQHI,
		OP_MQFIN,
		OP_MULK_FACT,
		OP_MULK_2M1,
		OP_MULK_2LL1,
		OP_MULK_LLM1,
		OP_NEG,
		OP_ST_PMM,
		OP_ST_P1,
		OP_T1,
		OP_SUB,
		OP_DIVI,
		OP_DIVS,
		OP_DIVF,
		OP_SHIFT,
		OP_OUT
	} dp_op_t;

	typedef struct packed {
		dp_op_t op;
	} dp_cmd_t;

	typedef struct packed {
		logic m_gt_l;
		logic m_zero;
		logic l_eq_m;
		logic cnt_last;
		logic sq_last;
		logic div_last;
		logic ll_gt_l;
	} dp_stat_t;

	typedef struct packed {
		logic          clip;
		logic [VW-1:0] val;
	} sat_t;

	function automatic sat_t from_sign_mag(input logic neg, input logic [VW-1:0] m);
		sat_t r;
		if (!neg) begin
			r.clip = m[VW-1];
			r.val  = m[VW-1] ? VMAX : m;
		end else begin
			r.clip = m > VMIN;
			r.val  = (m > VMIN) ? VMIN : (VW'(0) - m);
		end
		return r;
	endfunction

endpackage

FILE: sv/ale_datapath.sv
module ale_datapath #(
	parameter int MAX_BAND = 12
) (
	input  logic                         clk,
	input  ale_pkg::dp_cmd_t             cmd,
	input  logic [3:0]                   band,
	input  logic [3:0]                   order,
	input  logic signed [ale_pkg::XW-1:0] x_value,
	output ale_pkg::dp_stat_t            stat,
	output logic [ale_pkg::VW-1:0]       poly_value,
	output logic                         saturated
);

	localparam int unsigned VW = ale_pkg::VW;
	localparam int unsigned LW = ale_pkg::LW;
	localparam int unsigned KW = ale_pkg::KW;

	logic [LW-1:0] l_q, m_q, ll_q, cnt_q;
	logic signed [ale_pkg::XW-1:0] x_q;
	logic [31:0] a_q, b_q;
	logic [62:0] rad_q, res_q;
	logic [4:0] sq_cnt_q;
	logic [VW-1:0] w_q, pmm_q, p1_q, t1_q, plo_q, phi_q, dvd_q;
	logic [KW-1:0] fact_q;
	logic mq_neg_q, sign_q, clip_q;
	logic [LW-1:0] rem_q;
	logic [3:0] dcnt_q;
	logic [VW-1:0] out_val_q;
	logic out_sat_q;
	logic qsel_q;

	logic [LW-1:0] band_c, order_c;
	logic signed [ale_pkg::XW-1:0] x_c;
	logic [VW-1:0] w_mag;
	logic [30:0] x_mag;
	logic [31:0] hi_b;
	logic [31:0] mul_a, mul_b;
	logic [VW-1:0] mul_p;
	logic [62:0] bitv, trial;
	logic [VW-1:0] rsum;
	logic [KW-1:0] kval;
	logic [VW+KW-1:0] kprod;
	logic [VW:0] diff;
	logic [LW-1:0] dsr;
	logic [LW-1:0] r_w;
	logic [LW:0] r6;
	logic [3:0] qd;
	ale_pkg::sat_t mq_r, k_r, d_r;

	assign band_c  = ({1'b0, band} > LW'(MAX_BAND)) ? LW'(MAX_BAND) : {1'b0, band};
	assign order_c = ({1'b0, order} > LW'(MAX_BAND)) ? LW'(MAX_BAND) : {1'b0, order};
	assign x_c = (x_value > ale_pkg::ONE_Q30) ? ale_pkg::ONE_Q30 :
		(x_value < -ale_pkg::ONE_Q30) ? -ale_pkg::ONE_Q30 : x_value;

	assign w_mag = w_q[VW-1] ? (VW'(0) - w_q) : w_q;
	assign x_mag = x_q[31] ? 31'(-x_q) : x_q[30:0];
	assign hi_b  = qsel_q ? {1'b0, x_mag} : {1'b0, res_q[30:0]};

	always_comb begin
		mul_a = a_q;
		mul_b = b_q;
		case (cmd.op)
			ale_pkg::OP_MQLO_S: begin
				mul_a = w_mag[31:0];
				mul_b = {1'b0, res_q[30:0]};
			end
			ale_pkg::OP_MQLO_X: begin
				mul_a = w_mag[31:0];
				mul_b = {1'b0, x_mag};
			end
			ale_pkg::OP_MQHI: begin
				mul_a = w_mag[63:32];
				mul_b = hi_b;
			end
			default: begin
				mul_a = a_q;
				mul_b = b_q;
			end
		endcase
	end

	assign mul_p = 64'(mul_a) * 64'(mul_b);

	assign bitv  = 63'(1) << {sq_cnt_q, 1'b0};
	assign trial = res_q + bitv;

	assign rsum = {phi_q[61:0], 2'b00} + ((plo_q + (VW'(1) << 29)) >> 30);
	assign mq_r = ale_pkg::from_sign_mag(mq_neg_q, rsum);

	always_comb begin
		case (cmd.op)
			ale_pkg::OP_MULK_FACT: kval = fact_q;
			ale_pkg::OP_MULK_2M1:  kval = {m_q, 1'b1};
			ale_pkg::OP_MULK_2LL1: kval = {ll_q, 1'b0} - KW'(1);
			ale_pkg::OP_MULK_LLM1: kval = KW'(ll_q) + KW'(m_q) - KW'(1);
			default:               kval = KW'(1);
		endcase
	end

	assign kprod = (VW+KW)'(w_mag) * (VW+KW)'(kval);
	always_comb begin
		if (|kprod[VW+KW-1:VW]) begin
			k_r.clip = 1'b1;
			k_r.val  = w_q[VW-1] ? ale_pkg::VMIN : ale_pkg::VMAX;
		end else begin
			k_r = ale_pkg::from_sign_mag(w_q[VW-1], kprod[VW-1:0]);
		end
	end

	assign diff = {t1_q[VW-1], t1_q} - {w_q[VW-1], w_q};

	assign dsr = ll_q - m_q;
	always_comb begin
		r_w = rem_q;
		r6  = '0;
		qd  = '0;
		for (int i = 3; i >= 0; i--) begin
			r6 = {r_w, dvd_q[VW-4+i]};
			if (r6 >= {1'b0, dsr}) begin
				r6    = r6 - {1'b0, dsr};
				qd[i] = 1'b1;
			end
			r_w = r6[LW-1:0];
		end
	end
	assign d_r = ale_pkg::from_sign_mag(sign_q, dvd_q);

	always_ff @(posedge clk) begin
		case (cmd.op)
			ale_pkg::OP_LOAD: begin
				l_q    <= band_c;
				m_q    <= order_c;
				x_q    <= x_c;
				a_q    <= 32'(33'sd1073741824 - 33'(x_c));
				b_q    <= 32'(33'sd1073741824 + 33'(x_c));
				cnt_q  <= order_c;
				fact_q <= KW'(1);
				clip_q <= 1'b0;
			end
			ale_pkg::OP_RAD: begin
				rad_q    <= mul_p[62:0];
				res_q    <= '0;
				sq_cnt_q <= 5'd31;
			end
			ale_pkg::OP_SQRT: begin
				if (rad_q >= trial) begin
					rad_q <= rad_q - trial;
					res_q <= (res_q >> 1) + bitv;
				end else begin
					res_q <= res_q >> 1;
				end
				sq_cnt_q <= sq_cnt_q - 5'd1;
			end
			ale_pkg::OP_W_ONE:  w_q <= ale_pkg::ONE_Q20;
			ale_pkg::OP_W_ZERO: w_q <= '0;
			ale_pkg::OP_W_P1:   w_q <= p1_q;
			ale_pkg::OP_MQLO_S: begin
				plo_q    <= mul_p;
				mq_neg_q <= w_q[VW-1];
				qsel_q   <= 1'b0;
			end
			ale_pkg::OP_MQLO_X: begin
				plo_q    <= mul_p;
				mq_neg_q <= w_q[VW-1] ^ x_q[31];
				qsel_q   <= 1'b1;
			end
			ale_pkg::OP_MQHI: phi_q <= mul_p;
			ale_pkg::OP_MQFIN: begin
				w_q    <= mq_r.val;
				clip_q <= clip_q | mq_r.clip;
			end
			ale_pkg::OP_MULK_FACT, ale_pkg::OP_MULK_2M1,
			ale_pkg::OP_MULK_2LL1, ale_pkg::OP_MULK_LLM1: begin
				w_q    <= k_r.val;
				clip_q <= clip_q | k_r.clip;
			end
			ale_pkg::OP_NEG: begin
				if (w_q == ale_pkg::VMIN) begin
					w_q    <= ale_pkg::VMAX;
					clip_q <= 1'b1;
				end else begin
					w_q <= VW'(0) - w_q;
				end
				fact_q <= fact_q + KW'(2);
				cnt_q  <= cnt_q - LW'(1);
			end
			ale_pkg::OP_ST_PMM: pmm_q <= w_q;
			ale_pkg::OP_ST_P1: begin
				p1_q <= w_q;
				ll_q <= m_q + LW'(2);
			end
			ale_pkg::OP_T1: begin
				t1_q <= w_q;
				w_q  <= pmm_q;
			end
			ale_pkg::OP_SUB: begin
				if (diff[VW] != diff[VW-1]) begin
					w_q    <= diff[VW] ? ale_pkg::VMIN : ale_pkg::VMAX;
					clip_q <= 1'b1;
				end else begin
					w_q <= diff[VW-1:0];
				end
			end
			ale_pkg::OP_DIVI: begin
				sign_q <= w_q[VW-1];
				dvd_q  <= w_mag + VW'(dsr >> 1);
				rem_q  <= '0;
				dcnt_q <= 4'd15;
			end
			ale_pkg::OP_DIVS: begin
				dvd_q  <= {dvd_q[VW-5:0], qd};
				rem_q  <= r_w;
				dcnt_q <= dcnt_q - 4'd1;
			end
			ale_pkg::OP_DIVF: begin
				w_q    <= d_r.val;
				clip_q <= clip_q | d_r.clip;
				ll_q   <= ll_q + LW'(1);
			end
			ale_pkg::OP_SHIFT: begin
				pmm_q <= p1_q;
				p1_q  <= w_q;
			end
			ale_pkg::OP_OUT: begin
				out_val_q <= w_q;
				out_sat_q <= clip_q;
			end
			default: begin
				w_q <= w_q;
			end
		endcase
	end

	assign stat.m_gt_l   = m_q > l_q;
	assign stat.m_zero   = m_q == '0;
	assign stat.l_eq_m   = l_q == m_q;
	assign stat.cnt_last = cnt_q == LW'(1);
	assign stat.sq_last  = sq_cnt_q == '0;
	assign stat.div_last = dcnt_q == '0;
	assign stat.ll_gt_l  = ll_q > l_q;

	assign poly_value = out_val_q;
	assign saturated  = out_sat_q;

endmodule

FILE: sv/ale_ctrl.sv
module ale_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	output logic              out_valid,
	input  logic              out_ready,
	input  ale_pkg::dp_stat_t stat,
	output ale_pkg::dp_cmd_t  cmd
);

	typedef enum logic [19:0] {
		S_IDLE   = 20'h00001,
		S_RAD    = 20'h00002,
		S_SQRT   = 20'h00004,
		S_PREP   = 20'h00008,
		S_MQLO   = 20'h00010,
		S_MQHI   = 20'h00020,
		S_MQFIN  = 20'h00040,
		S_MULK   = 20'h00080,
		S_NEG    = 20'h00100,
		S_PMMEND = 20'h00200,
		S_ST1    = 20'h00400,
		S_LOOP   = 20'h00800,
		S_T1     = 20'h01000,
		S_MULK2  = 20'h02000,
		S_SUB    = 20'h04000,
		S_DIVI   = 20'h08000,
		S_DIVS   = 20'h10000,
		S_DIVF   = 20'h20000,
		S_SHIFT  = 20'h40000,
		S_DONE   = 20'h80000
	} state_t;

	typedef enum logic [1:0] {
		CTX_PMM,
		CTX_P1,
		CTX_REC
	} ctx_t;

	state_t state_q, state_d;
	ctx_t ctx_q, ctx_d;
	logic out_valid_q;

	always_comb begin
		state_d = state_q;
		ctx_d   = ctx_q;
		cmd.op  = ale_pkg::OP_NOP;
		case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					cmd.op  = ale_pkg::OP_LOAD;
					state_d = S_RAD;
				end
			end
			S_RAD: begin
				cmd.op  = ale_pkg::OP_RAD;
				state_d = S_SQRT;
			end
			S_SQRT: begin
				cmd.op = ale_pkg::OP_SQRT;
				if (stat.sq_last) state_d = S_PREP;
			end
			S_PREP: begin
				if (stat.m_gt_l) begin
					cmd.op  = ale_pkg::OP_W_ZERO;
					state_d = S_DONE;
				end else begin
					cmd.op  = ale_pkg::OP_W_ONE;
					ctx_d   = CTX_PMM;
					state_d = stat.m_zero ? S_PMMEND : S_MQLO;
				end
			end
			S_MQLO: begin
				cmd.op  = (ctx_q == CTX_PMM) ? ale_pkg::OP_MQLO_S : ale_pkg::OP_MQLO_X;
				state_d = S_MQHI;
			end
			S_MQHI: begin
				cmd.op  = ale_pkg::OP_MQHI;
				state_d = S_MQFIN;
			end
			S_MQFIN: begin
				cmd.op  = ale_pkg::OP_MQFIN;
				state_d = S_MULK;
			end
			S_MULK: begin
				case (ctx_q)
					CTX_PMM: begin
						cmd.op  = ale_pkg::OP_MULK_FACT;
						state_d = S_NEG;
					end
					CTX_P1: begin
						cmd.op  = ale_pkg::OP_MULK_2M1;
						state_d = S_ST1;
					end
					default: begin
						cmd.op  = ale_pkg::OP_MULK_2LL1;
						state_d = S_T1;
					end
				endcase
			end
			S_NEG: begin
				cmd.op  = ale_pkg::OP_NEG;
				state_d = stat.cnt_last ? S_PMMEND : S_MQLO;
			end
			S_PMMEND: begin
				cmd.op = ale_pkg::OP_ST_PMM;
				if (stat.l_eq_m) begin
					state_d = S_DONE;
				end else begin
					ctx_d   = CTX_P1;
					state_d = S_MQLO;
				end
			end
			S_ST1: begin
				cmd.op  = ale_pkg::OP_ST_P1;
				state_d = S_LOOP;
			end
			S_LOOP: begin
				if (stat.ll_gt_l) begin
					state_d = S_DONE;
				end else begin
					cmd.op  = ale_pkg::OP_W_P1;
					ctx_d   = CTX_REC;
					state_d = S_MQLO;
				end
			end
			S_T1: begin
				cmd.op  = ale_pkg::OP_T1;
				state_d = S_MULK2;
			end
			S_MULK2: begin
				cmd.op  = ale_pkg::OP_MULK_LLM1;
				state_d = S_SUB;
			end
			S_SUB: begin
				cmd.op  = ale_pkg::OP_SUB;
				state_d = S_DIVI;
			end
			S_DIVI: begin
				cmd.op  = ale_pkg::OP_DIVI;
				state_d = S_DIVS;
			end
			S_DIVS: begin
				cmd.op = ale_pkg::OP_DIVS;
				if (stat.div_last) state_d = S_DIVF;
			end
			S_DIVF: begin
				cmd.op  = ale_pkg::OP_DIVF;
				state_d = S_SHIFT;
			end
			S_SHIFT: begin
				cmd.op  = ale_pkg::OP_SHIFT;
				state_d = S_LOOP;
			end
			S_DONE: begin
				if (!out_valid_q || out_ready) begin
					cmd.op  = ale_pkg::OP_OUT;
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			ctx_q       <= CTX_PMM;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			ctx_q   <= ctx_d;
			if (cmd.op == ale_pkg::OP_OUT) out_valid_q <= 1'b1;
			else if (out_ready) out_valid_q <= 1'b0;
		end
	end

	assign in_ready  = state_q == S_IDLE;
	assign out_valid = out_valid_q;

endmodule

FILE: sv/associated_legendre_eval_top.sv
// Associated Legendre polynomial P(l,m,x), Condon-Shortley sign included.
// Input channel s_*: one item per evaluation, tdata = band, order, x_value
// (Q1.30). Output channel m_*: one item per input, tdata = poly_value
// (signed Q.20), tuser = saturated.
// One item is in work at a time; s_tready is high only while idle.
// The work time, with l and m after clamping, is set by the 32-step
// bitwise square root, one shared 32x32 multiplier for the Q.30 products
// and a radix-16 divider per recurrence step.
// The result waits in an output register; a stalled receiver holds it and
// the block takes the next item meanwhile, finishing it only once the
// register is free. Reset clears the controller and drops any item in
// work and any result not yet taken.
module associated_legendre_eval_top #(
	parameter int MAX_BAND = 12
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [39:0] s_tdata,  // band[3:0], order[7:4], x_value[39:8]
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [63:0] m_tdata,  // poly_value[63:0]
	output logic [0:0]  m_tuser   // saturated[0]
);

	ale_pkg::dp_cmd_t  cmd;
	ale_pkg::dp_stat_t stat;
	logic sat;

	ale_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_tvalid),
		.in_ready  (s_tready),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.stat      (stat),
		.cmd       (cmd)
	);

	ale_datapath #(
		.MAX_BAND (MAX_BAND)
	) u_dp (
		.clk        (clk),
		.cmd        (cmd),
		.band       (s_tdata[3:0]),
		.order      (s_tdata[7:4]),
		.x_value    (s_tdata[39:8]),
		.stat       (stat),
		.poly_value (m_tdata),
		.saturated  (sat)
	);

	assign m_tuser = sat;

	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(s_tvalid && s_tready) |=> !s_tready)
		else $error("item accepted while busy");

	a_out_on_idle: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_tvalid) |-> s_tready)
		else $error("result raised outside return to idle");

endmodule

FILE: sim/tb_associated_legendre_eval_top.sv
module tb_associated_legendre_eval_top;

	localparam int MAX_BAND = 12;
	localparam longint V_MAX = 64'h7FFF_FFFF_FFFF_FFFF;
	localparam longint V_MIN = 64'h8000_0000_0000_0000;
	localparam longint Q30_ONE = 64'sd1073741824;

	typedef struct packed {
		logic [63:0] value;
		logic        clip;
	} legendre_res_t;

	logic        clk;
	logic        arst_n;
	logic        s_tvalid;
	logic        s_tready;
	logic [39:0] s_tdata;
	logic        m_tvalid;
	logic        m_tready;
	logic [63:0] m_tdata;
	logic [0:0]  m_tuser;

	legendre_res_t pending_values[$];
	int            mismatches;
	int            item_count;
	bit            recv_idle_on;

	associated_legendre_eval_top #(.MAX_BAND(MAX_BAND)) DUT (
		.clk(clk),
		.arst_n(arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata),
		.m_tuser(m_tuser)
	);

	always begin
		clk = 1'b1;
		#1;
		clk = 1'b0;
		#1;
	end

	bit step_clip;

	function automatic longint signed_of_mag(bit neg, logic [63:0] mg);
		if (!neg) begin
			if (mg[63]) begin
				step_clip = 1;
				return V_MAX;
			end
			return mg;
		end
		if (mg > 64'h8000_0000_0000_0000) begin
			step_clip = 1;
			return V_MIN;
		end
		return 64'd0 - mg;
	endfunction

	function automatic logic [63:0] mag_of(longint a);
		return a < 0 ? 64'd0 - a : a;
	endfunction

	function automatic longint scale_q30(longint a, longint q);
		logic [63:0] u, v, hi, lo, r;
		u = mag_of(a);
		v = mag_of(q);
		hi = u >> 32;
		lo = u & 64'hFFFF_FFFF;
		r = hi * v * 4 + ((lo * v + (64'd1 << 29)) >> 30);
		return signed_of_mag((a < 0) != (q < 0), r);
	endfunction

	function automatic longint scale_int(longint a, logic [63:0] k);
		logic [127:0] w;
		w = mag_of(a) * 128'(k);
		if (w[127:64] != 0) begin
			step_clip = 1;
			return a < 0 ? V_MIN : V_MAX;
		end
		return signed_of_mag(a < 0, w[63:0]);
	endfunction

	function automatic longint negate_sat(longint a);
		if (a == V_MIN) begin
			step_clip = 1;
			return V_MAX;
		end
		return -a;
	endfunction

	function automatic longint diff_sat(longint a, longint b);
		if (b > 0 && a < V_MIN + b) begin
			step_clip = 1;
			return V_MIN;
		end
		if (b < 0 && a > V_MAX + b) begin
			step_clip = 1;
			return V_MAX;
		end
		return a - b;
	endfunction

	function automatic longint divide_round(longint n, logic [63:0] d);
		return signed_of_mag(n < 0, (mag_of(n) + d / 2) / d);
	endfunction

	function automatic logic [63:0] root_floor(logic [63:0] n);
		logic [63:0] res, bitv;
		res = 0;
		bitv = 64'd1 << 62;
		while (bitv > n) bitv >>= 2;
		while (bitv != 0) begin
			if (n >= res + bitv) begin
				n -= res + bitv;
				res = (res >> 1) + bitv;
			end else begin
				res >>= 1;
			end
			bitv >>= 2;
		end
		return res;
	endfunction

	function automatic legendre_res_t legendre_value(logic [3:0] band, logic [3:0] order,
			logic [31:0] x_raw);
		legendre_res_t r;
		int unsigned l, m, ll, i;
		longint x, pmm, pmmp1, pll, s, t1, t2;
		logic [63:0] fact;
		step_clip = 0;
		l = band > MAX_BAND ? MAX_BAND : band;
		m = order > MAX_BAND ? MAX_BAND : order;
		x = longint'(signed'(x_raw));
		if (x > Q30_ONE) x = Q30_ONE;
		if (x < -Q30_ONE) x = -Q30_ONE;
		if (m > l) begin
			pll = 0;
		end else begin
			pmm = 64'd1 << 20;
			if (m > 0) begin
				s = root_floor((Q30_ONE - x) * (Q30_ONE + x));
				fact = 1;
				for (i = 1; i <= m; i++) begin
					pmm = negate_sat(scale_int(scale_q30(pmm, s), fact));
					fact += 2;
				end
			end
			if (l == m) begin
				pll = pmm;
			end else begin
				pmmp1 = scale_int(scale_q30(pmm, x), 2 * m + 1);
				pll = pmmp1;
				for (ll = m + 2; ll <= l; ll++) begin
					t1 = scale_int(scale_q30(pmmp1, x), 2 * ll - 1);
					t2 = scale_int(pmm, ll + m - 1);
					pll = divide_round(diff_sat(t1, t2), ll - m);
					pmm = pmmp1;
					pmmp1 = pll;
				end
			end
		end
		r.value = pll;
		r.clip = step_clip;
		return r;
	endfunction

	task automatic send_item(logic [3:0] band, logic [3:0] order, logic [31:0] x_raw);
		int gap;
		gap = $urandom_range(0, 13);
		if ($urandom_range(0, 3) == 0) gap = 0;
		if (gap != 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		s_tdata <= {x_raw, order, band};
		s_tvalid <= 1'b1;
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		pending_values = {pending_values, legendre_value(band, order, x_raw)};
		item_count++;
		@(negedge clk);
	endtask

	function automatic logic [31:0] random_x();
		case ($urandom_range(0, 7))
			0: return 32'h4000_0000;
			1: return 32'hC000_0000;
			2: return $urandom();
			3: return 32'(longint'($urandom_range(0, 2000)) - 1000);
			default: return 32'(longint'($urandom_range(0, 32'h8000_0000)) - Q30_ONE);
		endcase
	endfunction

	task automatic drain_wait();
		s_tvalid <= 1'b0;
		while (pending_values.size() != 0) @(negedge clk);
	endtask

	task automatic test_extremes();
		send_item(4'd0, 4'd0, 32'h0000_0000);
		send_item(4'd12, 4'd12, 32'h0000_0000);
		send_item(4'd12, 4'd0, 32'h4000_0000);
		send_item(4'd12, 4'd0, 32'hC000_0000);
		send_item(4'd12, 4'd1, 32'h4000_0000);
		send_item(4'd12, 4'd12, 32'hC000_0000);
		send_item(4'd15, 4'd15, 32'h2000_0000);
		send_item(4'd15, 4'd3, 32'h7FFF_FFFF);
		send_item(4'd7, 4'd2, 32'h8000_0000);
		send_item(4'd3, 4'd9, 32'h1234_5678);
		send_item(4'd0, 4'd15, 32'hFFFF_FFFF);
		send_item(4'd5, 4'd5, 32'h3000_0000);
		send_item(4'd1, 4'd0, 32'h0000_0001);
		send_item(4'd12, 4'd6, 32'hE000_0000);
		send_item(4'd10, 4'd3, 32'h5555_5555);
		send_item(4'd12, 4'd11, 32'h2AAA_AAAA);
	endtask

	task automatic test_random(int count);
		int k;
		logic [3:0] band, order;
		for (k = 0; k < count; k++) begin
			if ($urandom_range(0, 9) == 0) begin
				band = 4'($urandom());
				order = 4'($urandom());
			end else begin
				band = 4'($urandom_range(0, 12));
				order = 4'($urandom_range(0, band));
			end
			send_item(band, order, random_x());
			if (k == count / 2) drain_wait();
		end
	endtask

	always @(posedge clk) begin
		if (m_tvalid && m_tready) begin
			if (pending_values.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected result %h sat %b", m_tdata, m_tuser);
			end else begin
				if (m_tdata !== pending_values[0].value ||
						m_tuser[0] !== pending_values[0].clip) begin
					mismatches++;
					if (mismatches <= 10)
						$display("mismatch: expected %h sat %b, got %h sat %b",
							pending_values[0].value, pending_values[0].clip,
							m_tdata, m_tuser);
				end
				void'(pending_values.pop_front());
			end
		end
	end

	initial begin
		int w;
		m_tready = 1'b0;
		forever begin
			@(negedge clk);
			if (m_tvalid) begin
				w = recv_idle_on ? $urandom_range(0, 13) : 0;
				if (w != 0) begin
					m_tready <= 1'b0;
					repeat (w) @(negedge clk);
				end
				m_tready <= 1'b1;
				@(posedge clk);
			end
		end
	end

	initial begin
		s_tvalid = 1'b0;
		s_tdata = '0;
		mismatches = 0;
		item_count = 0;
		recv_idle_on = 1'b1;
		arst_n = 1'b0;
		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		test_extremes();
		drain_wait();
		recv_idle_on = 1'b0;
		test_random(100);
		recv_idle_on = 1'b1;
		test_random(640);
		drain_wait();
		repeat (400) @(negedge clk);
		if (mismatches == 0 && pending_values.size() == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

	initial begin
		#5000000;
		$display("CHECK FAILED");
		$finish;
	end

endmodule
